>>> rtl/core/hcpu_pkg.sv
package hcpu_pkg;

  // Operation field IR[7:5]
  typedef enum logic [2:0] {
    OP_LD  = 3'd0,
    OP_AND = 3'd1,
    OP_OR  = 3'd2,
    OP_XOR = 3'd3,
    OP_ADD = 3'd4,
    OP_SUB = 3'd5,
    OP_ST  = 3'd6,
    OP_BR  = 3'd7
  } op_t;

  // Bus source IR[1:0]
  typedef enum logic [1:0] {
    BUS_D   = 2'd0,
    BUS_RAM = 2'd1,
    BUS_AC  = 2'd2,
    BUS_IN  = 2'd3
  } bus_t;

  // Addressing / destination mode IR[4:2]
  typedef enum logic [2:0] {
    MODE_D_AC    = 3'd0,
    MODE_X_AC    = 3'd1,
    MODE_YD_AC   = 3'd2,
    MODE_YX_AC   = 3'd3,
    MODE_D_X     = 3'd4,
    MODE_D_Y     = 3'd5,
    MODE_D_OUT   = 3'd6,
    MODE_YXI_OUT = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_AC,
    DST_X,
    DST_Y,
    DST_OUT
  } dest_t;

  localparam logic [15:0] PC_PAGE_MASK = 16'hff00;

  // RAM access request from the execute unit
  typedef struct packed {
    logic        rd_en;
    logic [15:0] rd_addr;
    logic        wr_en;
    logic [15:0] wr_addr;
    logic [7:0]  wr_data;
  } ram_req_t;

  // Architectural state after an instruction executes
  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  outp;
    logic [7:0]  ac;
    logic [7:0]  x;
    logic [7:0]  y;
  } res_t;

  // Full 16-bit data address selected by an instruction; the RAM cuts it.
  function automatic logic [15:0] mem_addr(input logic [7:0] ir, input logic [7:0] d,
                                           input logic [7:0] x, input logic [7:0] y);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = d;
    hi = 8'h00;
    if (op_t'(ir[7:5]) != OP_BR) begin
      unique case (mode_t'(ir[4:2]))
        MODE_X_AC: lo = x;
        MODE_YD_AC: hi = y;
        MODE_YX_AC, MODE_YXI_OUT: begin
          lo = x;
          hi = y;
        end
        default: ;
      endcase
    end
    return {hi, lo};
  endfunction

endpackage

>>> rtl/core/hcpu_ram.sv
module hcpu_ram
  import hcpu_pkg::*;
#(
  parameter int RAM_ADDR_BITS = 15
) (
  input  logic       clk,
  input  ram_req_t   req,
  output logic [7:0] rdata
);

  localparam int Depth = 1 << RAM_ADDR_BITS;

  logic [7:0] mem [Depth];
  logic [7:0] rd_q;
  logic       fwd_hit;
  logic [7:0] fwd_data;
  logic [RAM_ADDR_BITS-1:0] waddr;
  logic [RAM_ADDR_BITS-1:0] raddr;

  assign waddr = req.wr_addr[RAM_ADDR_BITS-1:0];
  assign raddr = req.rd_addr[RAM_ADDR_BITS-1:0];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[waddr] <= req.wr_data;
    end
  end

  // read port, held between transfers
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_q <= mem[raddr];
    end
  end

  // forward a store into the read issued at the same edge
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      fwd_hit  <= req.wr_en && (waddr == raddr);
      fwd_data <= req.wr_data;
    end
  end

  assign rdata = fwd_hit ? fwd_data : rd_q;

endmodule

>>> rtl/core/hcpu_exec.sv
module hcpu_exec
  import hcpu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rom_instruction,
  input  logic [7:0] rom_operand,
  input  logic [7:0] input_port,
  input  logic [7:0] floating_bus,
  input  logic [7:0] ram_rdata,
  output ram_req_t   ram_req,
  output res_t       res
);

  logic [15:0] pc;
  logic [7:0]  ir;
  logic [7:0]  d;
  logic [7:0]  ac;
  logic [7:0]  x;
  logic [7:0]  y;
  logic [7:0]  outp;

  logic [15:0] pc_next;
  logic [7:0]  ac_next;
  logic [7:0]  x_next;
  logic [7:0]  y_next;
  logic [7:0]  outp_next;

  op_t   op;
  mode_t mode;
  bus_t  bsel;
  dest_t dest;
  logic  is_store;
  logic  inc_x;
  logic  [7:0] busv;
  logic  [7:0] alu;
  logic  [1:0] cond;

  assign op       = op_t'(ir[7:5]);
  assign mode     = mode_t'(ir[4:2]);
  assign bsel     = bus_t'(ir[1:0]);
  assign is_store = (op == OP_ST);

  // destination decode
  always_comb begin
    dest  = DST_NONE;
    inc_x = 1'b0;
    if (op != OP_BR) begin
      unique case (mode)
        MODE_D_AC, MODE_X_AC, MODE_YD_AC, MODE_YX_AC: dest = DST_AC;
        MODE_D_X:   dest = DST_X;
        MODE_D_Y:   dest = DST_Y;
        MODE_D_OUT: dest = DST_OUT;
        MODE_YXI_OUT: begin
          dest  = DST_OUT;
          inc_x = 1'b1;
        end
        default: dest = DST_NONE;
      endcase
      if (is_store && (dest == DST_AC || dest == DST_OUT)) begin
        dest = DST_NONE;
      end
    end
  end

  // data bus
  always_comb begin
    unique case (bsel)
      BUS_D:   busv = d;
      BUS_RAM: busv = is_store ? floating_bus : ram_rdata;
      BUS_AC:  busv = ac;
      BUS_IN:  busv = input_port;
      default: busv = d;
    endcase
  end

  // ALU
  always_comb begin
    unique case (op)
      OP_LD:   alu = busv;
      OP_AND:  alu = ac & busv;
      OP_OR:   alu = ac | busv;
      OP_XOR:  alu = ac ^ busv;
      OP_ADD:  alu = ac + busv;
      OP_SUB:  alu = ac - busv;
      OP_ST:   alu = ac;
      OP_BR:   alu = 8'h00 - ac;
      default: alu = busv;
    endcase
  end

  // register write-back
  always_comb begin
    ac_next   = ac;
    x_next    = x;
    y_next    = y;
    outp_next = outp;
    unique case (dest)
      DST_AC:  ac_next = alu;
      DST_X:   x_next = alu;
      DST_Y:   y_next = alu;
      DST_OUT: outp_next = alu;
      default: ;
    endcase
    if (inc_x) begin
      x_next = x + 8'd1;
    end
  end

  // program counter: far jump on mode 0, else branch within page on AC test
  assign cond = (ac == 8'h00) ? 2'd2 : {1'b0, ac[7]};

  always_comb begin
    pc_next = pc + 16'd1;
    if (op == OP_BR) begin
      if (mode == MODE_D_AC) begin
        pc_next = {y, busv};
      end else if (ir[2 + cond]) begin
        pc_next = (pc & PC_PAGE_MASK) | {8'h00, busv};
      end
    end
  end

  // RAM: store now, read for the instruction being latched
  always_comb begin
    ram_req.wr_en   = accept && is_store;
    ram_req.wr_addr = mem_addr(ir, d, x, y);
    ram_req.wr_data = busv;
    ram_req.rd_en   = accept;
    ram_req.rd_addr = mem_addr(rom_instruction, rom_operand, x_next, y_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      ir   <= '0;
      d    <= '0;
      ac   <= '0;
      x    <= '0;
      y    <= '0;
      outp <= '0;
    end else if (accept) begin
      pc   <= pc_next;
      ir   <= rom_instruction;
      d    <= rom_operand;
      ac   <= ac_next;
      x    <= x_next;
      y    <= y_next;
      outp <= outp_next;
    end
  end

  assign res = '{pc: pc_next, outp: outp_next, ac: ac_next, x: x_next, y: y_next};

endmodule

>>> rtl/core/hcpu_outq.sv
module hcpu_outq
  import hcpu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t din,
  input  logic out_stall,
  output logic full,
  output logic out_valid,
  output res_t dout
);

  res_t skid;
  logic skid_valid;
  logic pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        dout <= skid;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid <= din;
      end else begin
        dout <= din;
      end
    end
  end

endmodule

>>> rtl/core/harvard_8bit_cpu_cycle.sv
// Executes one step of an 8-bit Harvard CPU per transfer.
// Input channel (in_valid / in_stall): the two ROM bytes fetched at the last
// fetch_address, the input port byte and the floating-bus value. Each
// transfer executes the previously latched instruction and latches the new one.
// Output channel (out_valid / out_stall): new PC (fetch_address), OUT, AC, X, Y.
// Each result is registered in the output register, or in the skid register if
// the output is held. Throughput: one item per cycle while in_stall is low.
// The data RAM has a registered read; the read for an instruction is issued
// at the edge that latches it; a same-address store at that edge is forwarded.
// Reset (rst, synchronous): PC, IR, D, AC, X, Y and OUT go to zero; the RAM
// keeps its contents and is undefined until written. No clearing pass.
// Receiver stall: the result stays on the outputs; one more item is taken
// into a skid register, after which in_stall rises until the output drains.
module harvard_8bit_cpu_cycle
  import hcpu_pkg::*;
#(
  parameter int RAM_ADDR_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rom_instruction,
  input  logic [7:0]  rom_operand,
  input  logic [7:0]  input_port,
  input  logic [7:0]  floating_bus,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] fetch_address,
  output logic [7:0]  out_port_value,
  output logic [7:0]  acc_out,
  output logic [7:0]  x_out,
  output logic [7:0]  y_out
);

  logic     accept;
  logic     full;
  logic [7:0] ram_rdata;
  ram_req_t ram_req;
  res_t     res;
  res_t     dout;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  hcpu_ram #(
    .RAM_ADDR_BITS(RAM_ADDR_BITS)
  ) u_ram (
    .clk  (clk),
    .req  (ram_req),
    .rdata(ram_rdata)
  );

  hcpu_exec u_exec (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .rom_instruction(rom_instruction),
    .rom_operand    (rom_operand),
    .input_port     (input_port),
    .floating_bus   (floating_bus),
    .ram_rdata      (ram_rdata),
    .ram_req        (ram_req),
    .res            (res)
  );

  hcpu_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .din      (res),
    .out_stall(out_stall),
    .full     (full),
    .out_valid(out_valid),
    .dout     (dout)
  );

  assign fetch_address  = dout.pc;
  assign out_port_value = dout.outp;
  assign acc_out        = dout.ac;
  assign x_out          = dout.x;
  assign y_out          = dout.y;

endmodule
